/* rtl/skrt_pkg.sv */
// skrt_pkg: shared types and codes for the sorted key record table.
// Used by sorted_key_record_table and skrt_checker; no dependencies.
package skrt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam int KEY_W   = 20;
    localparam int QTY_W   = 32;
    localparam int PCT_W   = 10;
    localparam int PRICE_W = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int ECNT_W  = 9;

    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [QTY_W-1:0]   qty;
        logic [PCT_W-1:0]          pct;
        logic [PRICE_W-1:0]        price;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOCK_IN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOCK_OUT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SET_QTY   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SET_PCT   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SET_PRICE = 3'd7;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

endpackage

/* rtl/skrt_ram.sv */
// skrt_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module skrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sorted_key_record_table.sv */
// sorted_key_record_table: record table kept in ascending key order.
// Depends on skrt_pkg and skrt_ram.
//
//  channel | direction | handshake         | payload
//  s_      | in        | s_valid / s_ready | mode, key, quantity, percent, price_cents
//  m_      | out       | m_valid / m_ready | status, found_*, entry_count
//
// One item at a time: a registered-read RAM and one key comparator; each entry visited
// takes a read state, then a compare/write state, and ST_EMIT loads the result.
// Insert walks down from the top, moving each larger key up one slot, then writes the
// new record; lookup, modify and delete scan up from index 0, and delete then moves
// the entries above the hit down one slot. A new item is accepted only in ST_IDLE.
// Reset clears the state, the fill count and the output valid; a waiting result stalls only the output load.
module sorted_key_record_table #(
    parameter int TABLE_DEPTH = skrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [skrt_pkg::MODE_W-1:0]         s_mode,
    input  logic [skrt_pkg::KEY_W-1:0]          s_key,
    input  logic signed [skrt_pkg::QTY_W-1:0]   s_quantity,
    input  logic [skrt_pkg::PCT_W-1:0]          s_percent,
    input  logic [skrt_pkg::PRICE_W-1:0]        s_price_cents,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [skrt_pkg::STAT_W-1:0]         m_status,
    output logic [skrt_pkg::KEY_W-1:0]          m_found_key,
    output logic signed [skrt_pkg::QTY_W-1:0]   m_found_quantity,
    output logic [skrt_pkg::PCT_W-1:0]          m_found_percent,
    output logic [skrt_pkg::PRICE_W-1:0]        m_found_price,
    output logic [skrt_pkg::ECNT_W-1:0]         m_entry_count
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_MODIFY,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_EMIT
    } state_t;

    state_t                            state_reg, state_next;
    logic [skrt_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [skrt_pkg::KEY_W-1:0]        key_reg, key_next;
    logic signed [skrt_pkg::QTY_W-1:0] qty_reg, qty_next;
    logic [skrt_pkg::PCT_W-1:0]        pct_reg, pct_next;
    logic [skrt_pkg::PRICE_W-1:0]      price_reg, price_next;
    logic [ADDR_W-1:0]                 pos_reg, pos_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    skrt_pkg::rec_t                    rec_reg, rec_next;
    logic [skrt_pkg::STAT_W-1:0]       status_reg, status_next;

    logic                              m_valid_reg, m_valid_next;
    logic [skrt_pkg::STAT_W-1:0]       m_status_reg, m_status_next;
    skrt_pkg::rec_t                    m_rec_reg, m_rec_next;
    logic [skrt_pkg::ECNT_W-1:0]       m_count_reg, m_count_next;

    logic                              ram_we;
    logic [ADDR_W-1:0]                 ram_waddr, ram_raddr;
    logic [skrt_pkg::REC_W-1:0]        ram_wdata, ram_rdata;
    skrt_pkg::rec_t                    rd_rec, mod_rec, new_rec;
    logic signed [skrt_pkg::QTY_W:0]   qty_sum;
    logic [CNT_W-1:0]                  pos_ext;
    logic [CNT_W+skrt_pkg::ECNT_W-1:0] count_ext;

    skrt_ram #(
        .WIDTH (skrt_pkg::REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_rec    = skrt_pkg::rec_t'(ram_rdata);
    assign pos_ext   = CNT_W'(pos_reg);
    assign count_ext = {{skrt_pkg::ECNT_W{1'b0}}, count_next};

    always_comb begin
        new_rec.key   = key_reg;
        new_rec.qty   = qty_reg;
        new_rec.pct   = pct_reg;
        new_rec.price = price_reg;
    end

    // 33-bit add or subtract, clamped to the signed 32-bit range
    always_comb begin
        if (mode_reg == skrt_pkg::MODE_STOCK_OUT) begin
            qty_sum = {rec_reg.qty[skrt_pkg::QTY_W-1], rec_reg.qty}
                    - {qty_reg[skrt_pkg::QTY_W-1], qty_reg};
        end else begin
            qty_sum = {rec_reg.qty[skrt_pkg::QTY_W-1], rec_reg.qty}
                    + {qty_reg[skrt_pkg::QTY_W-1], qty_reg};
        end
        mod_rec = rec_reg;
        case (mode_reg)
            skrt_pkg::MODE_STOCK_IN, skrt_pkg::MODE_STOCK_OUT: begin
                if (qty_sum[skrt_pkg::QTY_W] != qty_sum[skrt_pkg::QTY_W-1]) begin
                    mod_rec.qty = qty_sum[skrt_pkg::QTY_W]
                                ? {1'b1, {(skrt_pkg::QTY_W-1){1'b0}}}
                                : {1'b0, {(skrt_pkg::QTY_W-1){1'b1}}};
                end else begin
                    mod_rec.qty = qty_sum[skrt_pkg::QTY_W-1:0];
                end
            end
            skrt_pkg::MODE_SET_QTY:   mod_rec.qty   = qty_reg;
            skrt_pkg::MODE_SET_PCT:   mod_rec.pct   = pct_reg;
            skrt_pkg::MODE_SET_PRICE: mod_rec.price = price_reg;
            default:                  mod_rec       = rec_reg;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        qty_next      = qty_reg;
        pct_next      = pct_reg;
        price_next    = price_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        rec_next      = rec_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_rec_next    = m_rec_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = rec_reg;
        ram_raddr     = pos_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next  = s_mode;
                    key_next   = s_key;
                    qty_next   = s_quantity;
                    pct_next   = s_percent;
                    price_next = s_price_cents;
                    if (s_mode == skrt_pkg::MODE_INSERT) begin
                        if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                            status_next = skrt_pkg::STATUS_FULL;
                            rec_next    = '0;
                            state_next  = ST_EMIT;
                        end else begin
                            pos_next   = ADDR_W'(count_reg);
                            state_next = (count_reg == '0) ? ST_INS_PUT : ST_INS_RD;
                        end
                    end else begin
                        pos_next = '0;
                        if (count_reg == '0) begin
                            status_next = skrt_pkg::STATUS_NOT_FOUND;
                            rec_next    = '0;
                            state_next  = ST_EMIT;
                        end else begin
                            state_next = ST_SRCH_RD;
                        end
                    end
                end
            end
            ST_INS_RD: begin
                ram_raddr  = pos_reg - ADDR_W'(1);
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                // larger key moves up one slot
                if (rd_rec.key > key_reg) begin
                    ram_we     = 1'b1;
                    ram_wdata  = rd_rec;
                    pos_next   = pos_reg - ADDR_W'(1);
                    state_next = (pos_reg == ADDR_W'(1)) ? ST_INS_PUT : ST_INS_RD;
                end else begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                ram_we      = 1'b1;
                ram_wdata   = new_rec;
                rec_next    = new_rec;
                status_next = skrt_pkg::STATUS_OK;
                count_next  = count_reg + CNT_W'(1);
                state_next  = ST_EMIT;
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (rd_rec.key == key_reg) begin
                    rec_next    = rd_rec;
                    status_next = skrt_pkg::STATUS_OK;
                    case (mode_reg)
                        skrt_pkg::MODE_DELETE: begin
                            count_next = count_reg - CNT_W'(1);
                            state_next = ST_DEL_RD;
                        end
                        skrt_pkg::MODE_LOOKUP: state_next = ST_EMIT;
                        default:               state_next = ST_MODIFY;
                    endcase
                end else if (pos_ext + CNT_W'(1) == count_reg) begin
                    status_next = skrt_pkg::STATUS_NOT_FOUND;
                    rec_next    = '0;
                    state_next  = ST_EMIT;
                end else begin
                    pos_next   = pos_reg + ADDR_W'(1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_MODIFY: begin
                ram_we     = 1'b1;
                ram_wdata  = mod_rec;
                rec_next   = mod_rec;
                state_next = ST_EMIT;
            end
            ST_DEL_RD: begin
                // count already reduced: entries above pos still to move down
                if (pos_ext < count_reg) begin
                    ram_raddr  = pos_reg + ADDR_W'(1);
                    state_next = ST_DEL_WR;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_DEL_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = rd_rec;
                pos_next   = pos_reg + ADDR_W'(1);
                state_next = ST_DEL_RD;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_rec_next    = rec_reg;
                    m_count_next  = count_ext[skrt_pkg::ECNT_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        qty_reg      <= qty_next;
        pct_reg      <= pct_next;
        price_reg    <= price_next;
        pos_reg      <= pos_next;
        rec_reg      <= rec_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_rec_reg    <= m_rec_next;
        m_count_reg  <= m_count_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_key      = m_rec_reg.key;
    assign m_found_quantity = m_rec_reg.qty;
    assign m_found_percent  = m_rec_reg.pct;
    assign m_found_price    = m_rec_reg.price;
    assign m_entry_count    = m_count_reg;

endmodule

/* rtl/skrt_checker.sv */
// skrt_checker: port-level assertions for sorted_key_record_table, and its bind.
// Depends on skrt_pkg.
module skrt_checker #(
    parameter int TABLE_DEPTH = skrt_pkg::DEFAULT_TABLE_DEPTH
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [skrt_pkg::STAT_W-1:0]         m_status,
    input logic [skrt_pkg::KEY_W-1:0]          m_found_key,
    input logic signed [skrt_pkg::QTY_W-1:0]   m_found_quantity,
    input logic [skrt_pkg::PCT_W-1:0]          m_found_percent,
    input logic [skrt_pkg::PRICE_W-1:0]        m_found_price,
    input logic [skrt_pkg::ECNT_W-1:0]         m_entry_count
);

    localparam logic [skrt_pkg::ECNT_W-1:0] FULL_COUNT = skrt_pkg::ECNT_W'(TABLE_DEPTH);

    logic no_record;
    assign no_record = (m_found_key == '0) && (m_found_quantity == '0)
                    && (m_found_percent == '0) && (m_found_price == '0);

    // one item at a time: an accepted item closes the input
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still ready right after an accepted item");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
                                   && $stable(m_found_key) && $stable(m_entry_count)))
        else $error("stalled result changed");

    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == skrt_pkg::STATUS_FULL)
            |-> (no_record && m_entry_count == FULL_COUNT))
        else $error("table-full result with record data or wrong count");

    a_miss_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == skrt_pkg::STATUS_NOT_FOUND) |-> no_record)
        else $error("not-found result carries record data");

endmodule

bind sorted_key_record_table skrt_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_skrt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_found_key      (m_found_key),
    .m_found_quantity (m_found_quantity),
    .m_found_percent  (m_found_percent),
    .m_found_price    (m_found_price),
    .m_entry_count    (m_entry_count)
);
